// ----- sv/fgmc_pkg.sv -----
package fgmc_pkg;

  // func field codes
  localparam logic [1:0] FUNC_RUN     = 2'd0;
  localparam logic [1:0] FUNC_PRELOAD = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  // opcodes
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_ADDI  = 3'd3;
  localparam logic [2:0] OP_SUBI  = 3'd4;
  localparam logic [2:0] OP_LOAD  = 3'd5;
  localparam logic [2:0] OP_STORE = 3'd6;
  localparam logic [2:0] OP_HALT  = 3'd7;

  localparam int DMEM_AW = 10;

  typedef enum logic [1:0] {
    REG_THREADS   = 2'd0,
    REG_LOAD_LAT  = 2'd1,
    REG_STORE_LAT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic       wr;
    logic [1:0] idx;
    logic [7:0] data;
  } cfg_wr_t;

  // control snapshot taken after an item's effect
  typedef struct packed {
    logic [2:0]  fetch_thread;
    logic [11:0] fetch_line;
    logic        idle;
    logic        done_res;
    logic [31:0] cycle_count;
    logic [31:0] instr_count;
  } snap_t;

endpackage

// ----- sv/fgmc_if.sv -----
interface fgmc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [2:0]         opcode;
  logic [2:0]         dst_reg;
  logic [2:0]         src1_reg;
  logic signed [31:0] src2_or_imm;
  logic               is_imm;
  logic [9:0]         mem_addr;
  logic signed [31:0] mem_data;
  logic [2:0]         read_thread;
  logic [2:0]         read_reg;

  modport source (output valid, func, opcode, dst_reg, src1_reg, src2_or_imm, is_imm,
                  mem_addr, mem_data, read_thread, read_reg, input ready);
  modport sink (input valid, func, opcode, dst_reg, src1_reg, src2_or_imm, is_imm,
                mem_addr, mem_data, read_thread, read_reg, output ready);
endinterface

interface fgmc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         fetch_thread;
  logic [11:0]        fetch_line;
  logic               idle;
  logic               done_res;
  logic [31:0]        cycle_count;
  logic [31:0]        instr_count;
  logic signed [31:0] read_value;

  modport source (output valid, fetch_thread, fetch_line, idle, done_res, cycle_count,
                  instr_count, read_value, input ready);
  modport sink (input valid, fetch_thread, fetch_line, idle, done_res, cycle_count,
                instr_count, read_value, output ready);
endinterface

// ----- sv/fgmc_dmem.sv -----
module fgmc_dmem import fgmc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [DMEM_AW-1:0] addr,
  input  logic [31:0]        wdata,
  output logic [31:0]        rdata
);

  logic [31:0] mem [2**DMEM_AW];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/fgmc_rf.sv -----
module fgmc_rf #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  input  logic [AW-1:0] raddr2,
  output logic [31:0]   q0,
  output logic [31:0]   q1,
  output logic [31:0]   q2
);

  // two copies written alike: bank_a serves ports 0/1, bank_b port 2
  logic [31:0]      bank_a [DEPTH];
  logic [31:0]      bank_b [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [31:0]      d0_r, d1_r, d2_r;
  logic             v0_r, v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (we) begin
      bank_a[waddr] <= wdata;
      bank_b[waddr] <= wdata;
    end
    if (re) begin
      d0_r <= bank_a[raddr0];
      d1_r <= bank_a[raddr1];
      d2_r <= bank_b[raddr2];
      v0_r <= vld_r[raddr0];
      v1_r <= vld_r[raddr1];
      v2_r <= vld_r[raddr2];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  assign q0 = v0_r ? d0_r : 32'd0;
  assign q1 = v1_r ? d1_r : 32'd0;
  assign q2 = v2_r ? d2_r : 32'd0;

endmodule

// ----- sv/fgmc_ctrl.sv -----
module fgmc_ctrl import fgmc_pkg::*; #(
  parameter int MAX_THREADS = 8,
  parameter int TW          = 3,
  parameter int NW          = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [1:0]    func,
  input  logic [2:0]    opcode,
  input  cfg_wr_t       cfg,
  input  logic [1:0]    rd_idx,
  output logic [31:0]   rd_data,
  output logic [TW-1:0] cur_thread,
  output logic          issued,
  output snap_t         snap
);

  logic [3:0]             tiu_r, tiu_nxt;
  logic [7:0]             ll_r, ll_nxt;
  logic [7:0]             sl_r, sl_nxt;
  logic [11:0]            line_r [MAX_THREADS];
  logic [11:0]            line_nxt [MAX_THREADS];
  logic [8:0]             wait_r [MAX_THREADS];
  logic [8:0]             wait_nxt [MAX_THREADS];
  logic [MAX_THREADS-1:0] ready_r, ready_nxt;
  logic [MAX_THREADS-1:0] halted_r, halted_nxt;
  logic [MAX_THREADS-1:0] waiting;
  logic [TW-1:0]          cur_r, cur_nxt;
  logic                   idle_r, idle_nxt;
  logic [31:0]            cyc_r, cyc_nxt;
  logic [31:0]            ins_r, ins_nxt;
  logic [NW-1:0]          n, n_nxt, n_cfg;
  logic                   can, run, found, ok;
  logic [TW:0]            start;

  function automatic logic [NW-1:0] clamp_n(input logic [3:0] v);
    return (32'(v) > MAX_THREADS) ? NW'(MAX_THREADS) : NW'(v);
  endfunction

  function automatic logic halted_all(input logic [MAX_THREADS-1:0] h,
                                      input logic [NW-1:0] cnt);
    logic r;
    r = 1'b1;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (NW'(i) < cnt && !h[i]) r = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    tiu_nxt    = tiu_r;
    ll_nxt     = ll_r;
    sl_nxt     = sl_r;
    line_nxt   = line_r;
    wait_nxt   = wait_r;
    ready_nxt  = ready_r;
    halted_nxt = halted_r;
    cur_nxt    = cur_r;
    idle_nxt   = idle_r;
    cyc_nxt    = cyc_r;
    ins_nxt    = ins_r;
    found      = 1'b0;
    start      = '0;

    n      = clamp_n(tiu_r);
    can    = !idle_r && (NW'(cur_r) < n) && ready_r[cur_r];
    run    = fire && func == FUNC_RUN && !halted_all(halted_r, n);
    issued = run && can;

    if (issued) begin
      if (ins_r != '1) ins_nxt = ins_r + 32'd1;
      if (opcode == OP_HALT) begin
        halted_nxt[cur_r] = 1'b1;
        ready_nxt[cur_r]  = 1'b0;
      end else if (opcode == OP_LOAD) begin
        wait_nxt[cur_r]  = {1'b0, ll_r} + 9'd1;
        ready_nxt[cur_r] = 1'b0;
      end else if (opcode == OP_STORE) begin
        wait_nxt[cur_r]  = {1'b0, sl_r} + 9'd1;
        ready_nxt[cur_r] = 1'b0;
      end
      line_nxt[cur_r] = line_r[cur_r] + 12'd1;
    end

    if (run) begin
      if (cyc_r != '1) cyc_nxt = cyc_r + 32'd1;
      for (int i = 0; i < MAX_THREADS; i++) begin
        if (wait_nxt[i] != 9'd0) begin
          wait_nxt[i] = wait_nxt[i] - 9'd1;
          if (wait_nxt[i] == 9'd0 && NW'(i) < n && !halted_nxt[i]) ready_nxt[i] = 1'b1;
        end
      end
      // round robin: after the issuing thread, else from thread 0
      start = issued ? {1'b0, cur_r} + (TW+1)'(1) : '0;
      cur_nxt = '0;
      for (int i = 0; i < MAX_THREADS; i++) begin
        if (!found && ready_nxt[i] && NW'(i) < n && (TW+1)'(i) >= start) begin
          cur_nxt = TW'(i);
          found   = 1'b1;
        end
      end
      for (int i = 0; i < MAX_THREADS; i++) begin
        if (!found && ready_nxt[i] && NW'(i) < n) begin
          cur_nxt = TW'(i);
          found   = 1'b1;
        end
      end
      idle_nxt = !found;
    end

    n_cfg = clamp_n(cfg.data[3:0]);
    if (cfg.wr) begin
      unique case (cfg.idx)
        REG_THREADS: begin
          tiu_nxt = cfg.data[3:0];
          for (int i = 0; i < MAX_THREADS; i++) begin
            ready_nxt[i] = NW'(i) < n_cfg && !halted_r[i] && wait_r[i] == 9'd0;
          end
        end
        REG_LOAD_LAT:  ll_nxt = cfg.data;
        REG_STORE_LAT: sl_nxt = cfg.data;
        default: ;
      endcase
    end

    n_nxt = clamp_n(tiu_nxt);
    ok    = !idle_nxt && (NW'(cur_nxt) < n_nxt) && ready_nxt[cur_nxt];
    snap.fetch_thread = ok ? 3'(cur_nxt) : 3'd0;
    snap.fetch_line   = ok ? line_nxt[cur_nxt] : 12'd0;
    snap.idle         = !ok;
    snap.done_res     = halted_all(halted_nxt, n_nxt);
    snap.cycle_count  = cyc_nxt;
    snap.instr_count  = ins_nxt;
  end

  always_comb begin
    unique case (rd_idx)
      REG_THREADS:   rd_data = 32'(tiu_r);
      REG_LOAD_LAT:  rd_data = 32'(ll_r);
      REG_STORE_LAT: rd_data = 32'(sl_r);
      default:       rd_data = 32'd0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) waiting[i] = wait_r[i] != 9'd0;
  end

  assign cur_thread = cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiu_r    <= 4'd1;
      ll_r     <= '0;
      sl_r     <= '0;
      ready_r  <= MAX_THREADS'(1);
      halted_r <= '0;
      cur_r    <= '0;
      idle_r   <= 1'b0;
      cyc_r    <= '0;
      ins_r    <= '0;
      for (int i = 0; i < MAX_THREADS; i++) begin
        line_r[i] <= '0;
        wait_r[i] <= '0;
      end
    end else begin
      tiu_r    <= tiu_nxt;
      ll_r     <= ll_nxt;
      sl_r     <= sl_nxt;
      ready_r  <= ready_nxt;
      halted_r <= halted_nxt;
      cur_r    <= cur_nxt;
      idle_r   <= idle_nxt;
      cyc_r    <= cyc_nxt;
      ins_r    <= ins_nxt;
      line_r   <= line_nxt;
      wait_r   <= wait_nxt;
    end
  end

  a_ready_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_r & halted_r) == '0)
    else $error("halted thread marked ready");

  a_ready_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_r & waiting) == '0)
    else $error("parked thread marked ready");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (($past(halted_r) & ~halted_r) == '0))
    else $error("halted thread came back");

endmodule

// ----- sv/fine_grained_multithread_core.sv -----
// Fine-grained multithreaded (barrel) core.
// in_bus carries one beat per simulated core cycle (func run) or a side
// operation: preload a data memory word or read a thread register. out_bus
// returns exactly one beat per input beat, in order: the thread and line the
// next run beat must carry, idle/done flags, saturating cycle and
// instruction counters, and the read value.
// Thread control (lines, ready/park state, round robin pick, counters) is
// updated in the acceptance cycle. Register file and data memory are
// synchronous RAMs: operands are read at acceptance, execute/memory access
// happens in the execute stage, register writeback in the writeback stage,
// with forwarding from the two youngest writebacks.
// A taken beat passes through the execute stage into the output register,
// which drives its result beat.
// Throughput: one beat per clock while out_bus does not stall.
// Reset (rst_n low, synchronous): one thread running, latencies zero, all
// registers read as zero; data memory holds garbage until written.
// A stalled out_bus holds its beat; in_bus keeps taking beats until both the
// execute stage and the output register hold a beat that cannot move.
// Config (APB): 0x0 threads_in_use, 0x4 load_latency, 0x8 store_latency.
module fine_grained_multithread_core import fgmc_pkg::*; #(
  parameter int MAX_THREADS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  fgmc_in_if.sink       in_bus,
  fgmc_out_if.source    out_bus,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int NW = $clog2(MAX_THREADS + 1);
  localparam int AW = TW + 3;

  // handshake / stall
  logic adv, fire;

  // ctrl hookup
  cfg_wr_t       cfg;
  logic [TW-1:0] cur_thread;
  logic          issued;
  snap_t         snap;

  // stage 1 (execute)
  logic               s1_v_r;
  logic [1:0]         s1_func_r;
  logic [2:0]         s1_op_r;
  logic               s1_imm_r;
  logic [31:0]        s1_val_r;
  logic [9:0]         s1_maddr_r;
  logic [31:0]        s1_mdata_r;
  logic               s1_iss_r;
  logic               s1_rdok_r;
  snap_t              s1_snap_r;
  logic [AW-1:0]      s1_a0_r, s1_a1_r, s1_a2_r;

  // stage 2 (writeback) and last write
  logic               s2_wr_r, s2_ld_r;
  logic [AW-1:0]      s2_a_r;
  logic [31:0]        s2_alu_r, s2_val;
  logic               lw_v_r;
  logic [AW-1:0]      lw_a_r;
  logic [31:0]        lw_d_r;

  // read ports
  logic               rd_ok;
  logic [TW-1:0]      rd_thr;
  logic [AW-1:0]      a0, a1, a2;
  logic [31:0]        q0, q1, q2, o0, o1, o2, off;

  // execute results
  logic               ex_wr, ex_ld;
  logic [31:0]        ex_alu, rd_val;
  logic               dm_en, dm_we;
  logic [9:0]         dm_addr;
  logic [31:0]        dm_wd, dm_q;

  // output register
  logic               out_v_r;
  snap_t              out_snap_r;
  logic [31:0]        out_rv_r;

  assign adv          = !(s1_v_r && out_v_r && !out_bus.ready);
  assign in_bus.ready = adv;
  assign fire         = in_bus.valid && adv;

  assign cfg.wr  = psel && penable && pwrite;
  assign cfg.idx = paddr[3:2];
  assign cfg.data = pwdata[7:0];
  assign pready  = 1'b1;

  fgmc_ctrl #(.MAX_THREADS(MAX_THREADS), .TW(TW), .NW(NW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .func      (in_bus.func),
    .opcode    (in_bus.opcode),
    .cfg       (cfg),
    .rd_idx    (paddr[3:2]),
    .rd_data   (prdata),
    .cur_thread(cur_thread),
    .issued    (issued),
    .snap      (snap)
  );

  // operand addresses, taken at acceptance with the current thread (read thread for func read)
  always_comb begin
    rd_ok  = 32'(in_bus.read_thread) < 32'(MAX_THREADS);
    rd_thr = rd_ok ? TW'(in_bus.read_thread) : '0;
    a0 = (in_bus.func == FUNC_READ) ? {rd_thr, in_bus.read_reg}
                                    : {cur_thread, in_bus.src1_reg};
    a1 = {cur_thread, in_bus.src2_or_imm[2:0]};
    a2 = {cur_thread, in_bus.dst_reg};
  end

  fgmc_rf #(.DEPTH(MAX_THREADS * 8), .AW(AW)) u_rf (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (adv && s2_wr_r),
    .waddr (s2_a_r),
    .wdata (s2_val),
    .re    (adv),
    .raddr0(a0),
    .raddr1(a1),
    .raddr2(a2),
    .q0    (q0),
    .q1    (q1),
    .q2    (q2)
  );

  assign s2_val = s2_ld_r ? dm_q : s2_alu_r;

  // newest pending write wins
  function automatic logic [31:0] fwd(input logic [31:0] q, input logic [AW-1:0] a);
    logic [31:0] r;
    r = q;
    if (lw_v_r && lw_a_r == a) r = lw_d_r;
    if (s2_wr_r && s2_a_r == a) r = s2_val;
    return r;
  endfunction

  always_comb begin
    o0  = fwd(q0, s1_a0_r);
    o1  = fwd(q1, s1_a1_r);
    o2  = fwd(q2, s1_a2_r);
    off = s1_imm_r ? s1_val_r : o1;

    ex_wr   = 1'b0;
    ex_ld   = 1'b0;
    ex_alu  = '0;
    dm_en   = 1'b0;
    dm_we   = 1'b0;
    dm_addr = s1_maddr_r;
    dm_wd   = s1_mdata_r;

    if (s1_v_r && s1_func_r == FUNC_PRELOAD) begin
      dm_en = 1'b1;
      dm_we = 1'b1;
    end

    if (s1_v_r && s1_iss_r) begin
      unique case (s1_op_r)
        OP_ADD: begin
          ex_wr  = 1'b1;
          ex_alu = o0 + o1;
        end
        OP_SUB: begin
          ex_wr  = 1'b1;
          ex_alu = o0 - o1;
        end
        OP_ADDI: begin
          ex_wr  = s1_imm_r;
          ex_alu = o0 + s1_val_r;
        end
        OP_SUBI: begin
          ex_wr  = s1_imm_r;
          ex_alu = o0 - s1_val_r;
        end
        OP_LOAD: begin
          ex_wr   = 1'b1;
          ex_ld   = 1'b1;
          dm_en   = 1'b1;
          dm_addr = 10'(o0 + off);
        end
        OP_STORE: begin
          dm_en   = 1'b1;
          dm_we   = 1'b1;
          dm_addr = 10'(o2 + off);
          dm_wd   = o0;
        end
        OP_NOP, OP_HALT: ;
      endcase
    end

    rd_val = (s1_func_r == FUNC_READ && s1_rdok_r) ? o0 : 32'd0;
  end

  fgmc_dmem u_dmem (
    .clk  (clk),
    .en   (dm_en && adv),
    .we   (dm_we),
    .addr (dm_addr),
    .wdata(dm_wd),
    .rdata(dm_q)
  );

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_wr_r <= 1'b0;
      lw_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_r  <= fire;
        s2_wr_r <= ex_wr;
        lw_v_r  <= s2_wr_r;
      end
      if (adv && s1_v_r) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r  <= in_bus.func;
      s1_op_r    <= in_bus.opcode;
      s1_imm_r   <= in_bus.is_imm;
      s1_val_r   <= in_bus.src2_or_imm;
      s1_maddr_r <= in_bus.mem_addr;
      s1_mdata_r <= in_bus.mem_data;
      s1_iss_r   <= issued;
      s1_rdok_r  <= rd_ok;
      s1_snap_r  <= snap;
      s1_a0_r    <= a0;
      s1_a1_r    <= a1;
      s1_a2_r    <= a2;
      s2_ld_r    <= ex_ld;
      s2_a_r     <= s1_a2_r;
      s2_alu_r   <= ex_alu;
      lw_a_r     <= s2_a_r;
      lw_d_r     <= s2_val;
    end
    if (adv && s1_v_r) begin
      out_snap_r <= s1_snap_r;
      out_rv_r   <= rd_val;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.fetch_thread = out_snap_r.fetch_thread;
  assign out_bus.fetch_line   = out_snap_r.fetch_line;
  assign out_bus.idle         = out_snap_r.idle;
  assign out_bus.done_res     = out_snap_r.done_res;
  assign out_bus.cycle_count  = out_snap_r.cycle_count;
  assign out_bus.instr_count  = out_snap_r.instr_count;
  assign out_bus.read_value   = out_rv_r;

  a_exec_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_v_r |=> out_v_r)
    else $error("executed beat lost before output");

  a_stall_holds_exec: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r && $stable(s1_snap_r))
    else $error("execute stage moved under stall");

  a_load_holds_data: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ld_r && s2_wr_r && !adv |=> s2_ld_r && s2_wr_r && $stable(dm_q))
    else $error("load writeback data moved under stall");

endmodule
